// ===== rtl/core/dsn_pkg.sv =====
// ----------------------------------------------------------------------------
// dsn_pkg
// Shared types and constants for the depth surface normal block.
// ----------------------------------------------------------------------------
`default_nettype none

package dsn_pkg;

   localparam int DEPTH_W  = 16;
   localparam int DIFF_W   = 17;
   localparam int CFG_W    = 11;
   localparam int SQ_W     = 32;
   localparam int SUM_W    = 34;
   localparam int MAG_W    = 15;
   localparam int MAG_TOP  = 14;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W   = 2;

   // one pixel handed from the front end to the normalizer
   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic                     interior;
      logic                     frame_end;
   } work_type;

endpackage

`default_nettype wire

// ===== rtl/core/dsn_isqrt.sv =====
// ----------------------------------------------------------------------------
// dsn_isqrt
// Bit-serial search for floor(sqrt(num2) * 32768 / sqrt(s)), one bit a step.
// Tracks q*q*s and q*s so each step is adds and one compare.
// ----------------------------------------------------------------------------
`default_nettype none

module dsn_isqrt (
   input  logic                        clock,
   input  logic                        start,
   input  logic                        step,
   input  logic [3:0]                  bpos,
   input  logic [dsn_pkg::SQ_W-1:0]    num2,
   input  logic [dsn_pkg::SUM_W-1:0]   s,
   output logic [dsn_pkg::MAG_W-1:0]   mag
);
   import dsn_pkg::*;

   logic [61:0]        rhs_ff;
   logic [SUM_W-1:0]   s_ff;
   logic [65:0]        p_ff;
   logic [49:0]        qs_ff;
   logic [MAG_W-1:0]   q_ff;
   logic [65:0]        cand;
   logic               take;

   always_comb begin
      cand = p_ff + (66'(qs_ff) << (bpos + 4'd1)) + (66'(s_ff) << {bpos, 1'b0});
      take = cand <= {4'b0, rhs_ff};
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rhs_ff <= {num2, 30'b0};
         s_ff   <= s;
         p_ff   <= '0;
         qs_ff  <= '0;
         q_ff   <= '0;
      end else if (step && take) begin
         p_ff       <= cand;
         qs_ff      <= qs_ff + (50'(s_ff) << bpos);
         q_ff[bpos] <= 1'b1;
      end
   end

   assign mag = q_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dsn_front.sv =====
// ----------------------------------------------------------------------------
// dsn_front
// Raster counters, line buffer and left-pixel register; classifies each beat
// and forms the depth differences.
// ----------------------------------------------------------------------------
`default_nettype none

module dsn_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [dsn_pkg::CFG_W-1:0]   cfg_width,
   input  logic [dsn_pkg::CFG_W-1:0]   cfg_height,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [dsn_pkg::DEPTH_W-1:0] req_depth,
   output logic                        push_valid,
   input  logic                        push_ready,
   output dsn_pkg::work_type           push_data
);
   import dsn_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [DEPTH_W-1:0] line_mem [MAX_WIDTH];
   logic [DEPTH_W-1:0] above_ff;

   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [DEPTH_W-1:0] left_ff;

   logic               s1_valid_ff, s1_valid_in;
   logic [DEPTH_W-1:0] s1_centre_ff, s1_left_ff;
   logic               s1_interior_ff, s1_fend_ff;

   logic [12:0]        w13, h13;
   logic [CW:0]        w_lim;
   logic [RW:0]        h_lim;
   logic               last_col, last_row, interior, accept;

   always_comb begin
      w13 = 13'(cfg_width);
      h13 = 13'(cfg_height);
      if (w13 < 13'd3)                  w13 = 13'd3;
      else if (w13 > 13'(MAX_WIDTH))    w13 = 13'(MAX_WIDTH);
      if (h13 < 13'd3)                  h13 = 13'd3;
      else if (h13 > 13'(MAX_HEIGHT))   h13 = 13'(MAX_HEIGHT);
      w_lim = (CW+1)'(w13);
      h_lim = (RW+1)'(h13);
   end

   assign last_col = {1'b0, col_ff} >= (w_lim - 1'b1);
   assign last_row = {1'b0, row_ff} >= (h_lim - 1'b1);
   assign interior = (col_ff != '0) && !last_col && (row_ff != '0) && !last_row;

   assign req_ready = !s1_valid_ff || push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      s1_valid_in = accept ? 1'b1 : (push_ready ? 1'b0 : s1_valid_ff);
   end

   // read-before-write: above_ff gets the previous row's pixel
   always_ff @(posedge clock) begin
      if (accept) begin
         above_ff        <= line_mem[col_ff];
         line_mem[col_ff] <= req_depth;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         if (accept) left_ff <= req_depth;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_centre_ff   <= req_depth;
         s1_left_ff     <= left_ff;
         s1_interior_ff <= interior;
         s1_fend_ff     <= last_col && last_row;
      end
   end

   assign push_valid          = s1_valid_ff;
   assign push_data.dx        = $signed({1'b0, s1_left_ff}) - $signed({1'b0, s1_centre_ff});
   assign push_data.dy        = $signed({1'b0, above_ff}) - $signed({1'b0, s1_centre_ff});
   assign push_data.interior  = s1_interior_ff;
   assign push_data.frame_end = s1_fend_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dsn_fifo.sv =====
// ----------------------------------------------------------------------------
// dsn_fifo
// Short queue between the front end and the normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

module dsn_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  dsn_pkg::work_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output dsn_pkg::work_type pop_data
);
   import dsn_pkg::*;

   work_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = count_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/dsn_back.sv =====
// ----------------------------------------------------------------------------
// dsn_back
// Normalizer: squares the differences of an interior pixel, then runs three
// bit-serial magnitude searches in parallel; border pixels skip both. Holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module dsn_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  dsn_pkg::work_type           pop_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [15:0]          rsp_normal_x,
   output logic signed [15:0]          rsp_normal_y,
   output logic [14:0]                 rsp_normal_z,
   output logic                        rsp_normal_valid,
   output logic                        rsp_frame_end
);
   import dsn_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SQR  = 5'b00010,
      ST_SUM  = 5'b00100,
      ST_RUN  = 5'b01000,
      ST_OUT  = 5'b10000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   logic                     interior_ff, fend_ff;
   logic [SQ_W-1:0]          dx2_ff, dy2_ff;
   logic [3:0]               bpos_ff;
   logic signed [2*DIFF_W-1:0] dx_sq, dy_sq;
   logic [SUM_W-1:0]         s_sum;
   logic                     start, step;
   logic [MAG_W-1:0]         mag_x, mag_y, mag_z;

   assign dx_sq = dx_ff * dx_ff;
   assign dy_sq = dy_ff * dy_ff;
   assign s_sum = SUM_W'(dx2_ff) + SUM_W'(dy2_ff) + SUM_W'(1);
   assign start = state_ff == ST_SUM;
   assign step  = state_ff == ST_RUN;
   assign pop_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (pop_valid) state_in = pop_data.interior ? ST_SQR : ST_OUT;
         ST_SQR:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_RUN;
         ST_RUN:  if (bpos_ff == 4'd0) state_in = ST_OUT;
         ST_OUT:  if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && pop_valid) begin
         dx_ff       <= pop_data.dx;
         dy_ff       <= pop_data.dy;
         interior_ff <= pop_data.interior;
         fend_ff     <= pop_data.frame_end;
      end
      if (state_ff == ST_SQR) begin
         dx2_ff <= dx_sq[SQ_W-1:0];
         dy2_ff <= dy_sq[SQ_W-1:0];
      end
      if (start)               bpos_ff <= 4'(MAG_TOP);
      else if (step)           bpos_ff <= bpos_ff - 1'b1;
   end

   dsn_isqrt u_mag_x (.clock(clock), .start(start), .step(step), .bpos(bpos_ff),
                      .num2(dx2_ff), .s(s_sum), .mag(mag_x));
   dsn_isqrt u_mag_y (.clock(clock), .start(start), .step(step), .bpos(bpos_ff),
                      .num2(dy2_ff), .s(s_sum), .mag(mag_y));
   dsn_isqrt u_mag_z (.clock(clock), .start(start), .step(step), .bpos(bpos_ff),
                      .num2(SQ_W'(1)), .s(s_sum), .mag(mag_z));

   assign rsp_valid        = state_ff == ST_OUT;
   assign rsp_normal_valid = interior_ff;
   assign rsp_frame_end    = fend_ff;
   assign rsp_normal_x = !interior_ff ? 16'sd0 :
                         (dx_ff < 0 ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x}));
   assign rsp_normal_y = !interior_ff ? 16'sd0 :
                         (dy_ff < 0 ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y}));
   assign rsp_normal_z = interior_ff ? mag_z : 15'd0;

endmodule

`default_nettype wire

// ===== rtl/core/depth_surface_normal.sv =====
// Path: an input beat is registered in the front end and passed through the queue;
//   once popped, an interior pixel is squared, summed and run through the 15-step
//   magnitude search before its result beat; a border pixel goes straight to it.
// Pacing: the bit-serial normalizer takes a new pixel only in its idle state, so it
//   holds off the queue until the previous result beat is taken.
// Reset: synchronous; clears counters, queue and state, frame_width = 640,
//   frame_height = 480. The line buffer is not cleared.
// ----------------------------------------------------------------------------
// depth_surface_normal
// Per-pixel unit surface normal from a raster depth stream.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_surface_normal #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [15:0]  req_depth_sample,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic [14:0]  rsp_normal_z,
   output logic         rsp_normal_valid,
   output logic         rsp_frame_end,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import dsn_pkg::*;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   logic [CFG_W-1:0] width_ff, height_ff;
   logic             push_valid, push_ready, pop_valid, pop_ready;
   work_type         push_data, pop_data;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_HEIGHT) ? 32'(height_ff) : 32'(width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd640;
         height_ff <= 11'd480;
      end else if (wr_en) begin
         if (csr_paddr[2] == REG_WIDTH) width_ff  <= csr_pwdata[CFG_W-1:0];
         else                           height_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   dsn_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock(clock), .reset(reset),
      .cfg_width(width_ff), .cfg_height(height_ff),
      .req_valid(req_valid), .req_ready(req_ready), .req_depth(req_depth_sample),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
   );

   dsn_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
   );

   dsn_back u_back (
      .clock(clock), .reset(reset),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_normal_valid(rsp_normal_valid),
      .rsp_frame_end(rsp_frame_end)
   );

endmodule

`default_nettype wire

// ===== rtl/core/dsn_checker.sv =====
// ----------------------------------------------------------------------------
// dsn_port_checks
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dsn_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic signed [15:0] rsp_normal_x,
   input logic signed [15:0] rsp_normal_y,
   input logic [14:0] rsp_normal_z,
   input logic        rsp_normal_valid,
   input logic        rsp_frame_end
);

   // a stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_normal_x) &&
      $stable(rsp_normal_y) && $stable(rsp_normal_z) && $stable(rsp_frame_end))
      else $error("result beat changed while stalled");

   a_border: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_normal_valid |->
      rsp_normal_x == 16'sd0 && rsp_normal_y == 16'sd0 && rsp_normal_z == 15'd0)
      else $error("border beat with nonzero normal");

   // z only saturates for a flat patch
   a_flat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_normal_valid && rsp_normal_z == 15'h7fff |->
      rsp_normal_x == 16'sd0 && rsp_normal_y == 16'sd0)
      else $error("saturated z with tilted normal");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind depth_surface_normal dsn_port_checks u_dsn_port_checks (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
   .rsp_normal_z(rsp_normal_z), .rsp_normal_valid(rsp_normal_valid),
   .rsp_frame_end(rsp_frame_end)
);

`default_nettype wire
